[rtl/kms_pkg.sv]
package kms_pkg;

    // The key bitmaps are 32 bits wide, so at most 32 keys are tracked.
    localparam int KEY_SLOTS = 32;
    localparam int KEY_W     = 5;

    // Fixed field widths.
    localparam int LEVEL_W   = 8;
    localparam int DRIVE_W   = 4;
    localparam int ROWREG_W  = 3;
    localparam int COLREG_W  = 4;
    localparam int CFG_W     = 4;
    localparam int CFGIDX_W  = 1;

    // Command codes.
    localparam logic CMD_SCAN     = 1'b0;
    localparam logic CMD_SNAPSHOT = 1'b1;

    // Configuration register indexes.
    localparam logic [CFGIDX_W-1:0] REG_ROW_COUNT    = 1'b0;
    localparam logic [CFGIDX_W-1:0] REG_COLUMN_COUNT = 1'b1;

    // Register reset values.
    localparam logic [ROWREG_W-1:0] ROW_COUNT_RST    = 3'd4;
    localparam logic [COLREG_W-1:0] COLUMN_COUNT_RST = 4'd8;

    // One result word as it waits in the output queue.
    typedef struct packed {
        logic [DRIVE_W-1:0]   row_drive;
        logic [KEY_SLOTS-1:0] keys_down;
        logic [KEY_SLOTS-1:0] keys_pressed;
        logic [KEY_SLOTS-1:0] keys_released;
        logic                 selected_down;
        logic                 selected_pressed;
        logic                 selected_released;
    } t_result;

endpackage

[rtl/kms_key_lane.sv]
module kms_key_lane #(
    parameter int HIST_LEN = 8
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_we,
    input  logic                        i_closed,
    input  logic [$clog2(HIST_LEN)-1:0] i_pos,
    output logic                        o_down
);
    logic [HIST_LEN-1:0] r_hist;
    logic [HIST_LEN-1:0] n_hist;
    logic                r_down;
    logic                n_down;

    // Write the new sample at the current position, then check for a stable run.
    always_comb begin
        n_hist        = r_hist;
        n_hist[i_pos] = i_closed;
        n_down        = r_down;
        if (n_hist == '0) begin
            n_down = 1'b0;
        end else if (n_hist == '1) begin
            n_down = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist <= '0;
            r_down <= 1'b0;
        end else if (i_we) begin
            r_hist <= n_hist;
            r_down <= n_down;
        end
    end

    assign o_down = r_down;

endmodule

[rtl/kms_snap.sv]
module kms_snap (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_snap,
    input  logic [kms_pkg::KEY_SLOTS-1:0]  i_debounced,
    output logic [kms_pkg::KEY_SLOTS-1:0]  o_down,
    output logic [kms_pkg::KEY_SLOTS-1:0]  o_pressed,
    output logic [kms_pkg::KEY_SLOTS-1:0]  o_released
);
    import kms_pkg::*;

    logic [KEY_SLOTS-1:0] r_down;
    logic [KEY_SLOTS-1:0] r_pressed;
    logic [KEY_SLOTS-1:0] r_released;
    logic [KEY_SLOTS-1:0] n_down;
    logic [KEY_SLOTS-1:0] n_pressed;
    logic [KEY_SLOTS-1:0] n_released;

    // The outputs are the values after this cycle's command.
    always_comb begin
        n_down     = r_down;
        n_pressed  = r_pressed;
        n_released = r_released;
        if (i_snap) begin
            n_down     = i_debounced;
            n_pressed  = i_debounced & ~r_down;
            n_released = r_down & ~i_debounced;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_down     <= '0;
            r_pressed  <= '0;
            r_released <= '0;
        end else begin
            r_down     <= n_down;
            r_pressed  <= n_pressed;
            r_released <= n_released;
        end
    end

    assign o_down     = n_down;
    assign o_pressed  = n_pressed;
    assign o_released = n_released;

endmodule

[rtl/kms_out_q.sv]
module kms_out_q (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  kms_pkg::t_result i_data,
    output logic             o_full,
    output logic             o_valid,
    input  logic             i_pop,
    output kms_pkg::t_result o_data
);
    import kms_pkg::*;

    t_result    r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;
    logic       w_pop;

    assign w_pop   = i_pop && (r_cnt != 2'd0);
    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= ~r_wr;
            end
            if (w_pop) begin
                r_rd <= ~r_rd;
            end
            if (i_push && !w_pop) begin
                r_cnt <= r_cnt + 2'd1;
            end else if (!i_push && w_pop) begin
                r_cnt <= r_cnt - 2'd1;
            end
        end
    end

endmodule

[rtl/key_matrix_scan_debounce.sv]
// Channel   Valid     Stall     Word
// -------   -------   -------   ------------------------------------------------
// input     i_valid   o_stall   i_command, i_column_levels, i_key_index
// output    o_valid   i_stall   o_row_drive, o_keys_down/pressed/released,
//                               o_selected_down/pressed/released
// config    i_cfg_we  (none)    i_cfg_index, i_cfg_data
//
// Each accepted word is handled at once: the whole active row is updated
// by one lane per key slot, so one word can be accepted in every cycle
// while o_stall is low. Its result word is registered into the output queue.
// A two-entry output queue decouples the sides; o_stall rises only when both
// entries hold undelivered result words.
// Reset is synchronous and active low; it clears all histories, the debounced,
// latched and edge bitmaps, the row and history position counters, and the queue.
module key_matrix_scan_debounce #(
    parameter int MAX_ROWS       = 4,
    parameter int MAX_COLUMNS    = 8,
    parameter int HISTORY_LENGTH = 8
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_stall,
    input  logic                            i_command,
    input  logic [kms_pkg::LEVEL_W-1:0]     i_column_levels,
    input  logic [kms_pkg::KEY_W-1:0]       i_key_index,
    output logic                            o_valid,
    input  logic                            i_stall,
    output logic [kms_pkg::DRIVE_W-1:0]     o_row_drive,
    output logic [kms_pkg::KEY_SLOTS-1:0]   o_keys_down,
    output logic [kms_pkg::KEY_SLOTS-1:0]   o_keys_pressed,
    output logic [kms_pkg::KEY_SLOTS-1:0]   o_keys_released,
    output logic                            o_selected_down,
    output logic                            o_selected_pressed,
    output logic                            o_selected_released,
    input  logic                            i_cfg_we,
    input  logic [kms_pkg::CFGIDX_W-1:0]    i_cfg_index,
    input  logic [kms_pkg::CFG_W-1:0]       i_cfg_data
);
    import kms_pkg::*;

    localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int POS_W = $clog2(HISTORY_LENGTH);
    localparam logic [3:0]       ROWS_MAX = 4'(MAX_ROWS);
    localparam logic [3:0]       COLS_MAX = 4'(MAX_COLUMNS);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(HISTORY_LENGTH - 1);

    // Configuration registers; user writes only while block is idle (unchecked).
    logic [ROWREG_W-1:0] r_row_count;
    logic [COLREG_W-1:0] r_column_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count    <= ROW_COUNT_RST;
            r_column_count <= COLUMN_COUNT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_ROW_COUNT:    r_row_count    <= i_cfg_data[ROWREG_W-1:0];
                REG_COLUMN_COUNT: r_column_count <= i_cfg_data[COLREG_W-1:0];
                default:          ;
            endcase
        end
    end

    // Counts in use: zero counts as one, and anything past the maximum is capped.
    logic [3:0] w_rows;
    logic [3:0] w_cols;

    always_comb begin
        if (r_row_count == '0) begin
            w_rows = 4'd1;
        end else if ({1'b0, r_row_count} > ROWS_MAX) begin
            w_rows = ROWS_MAX;
        end else begin
            w_rows = {1'b0, r_row_count};
        end
        if (r_column_count == '0) begin
            w_cols = 4'd1;
        end else if (r_column_count > COLS_MAX) begin
            w_cols = COLS_MAX;
        end else begin
            w_cols = r_column_count;
        end
    end

    // Handshake and command decode.
    logic w_accept;
    logic w_tick;
    logic w_snap;
    logic w_q_full;

    assign o_stall  = w_q_full;
    assign w_accept = i_valid && !w_q_full;
    assign w_tick   = w_accept && (i_command == CMD_SCAN);
    assign w_snap   = w_accept && (i_command == CMD_SNAPSHOT);

    // Row and history position sequencing.
    logic [ROW_W-1:0] r_active_row;
    logic [ROW_W-1:0] n_active_row;
    logic [POS_W-1:0] r_hist_pos;
    logic [POS_W-1:0] n_hist_pos;
    logic [3:0]       w_row_ext;
    logic [3:0]       w_row_inc;
    logic             w_row_live;

    assign w_row_ext  = 4'(r_active_row);
    assign w_row_inc  = w_row_ext + 4'd1;
    assign w_row_live = (w_row_ext < w_rows);

    always_comb begin
        n_active_row = r_active_row;
        n_hist_pos   = r_hist_pos;
        if (w_tick) begin
            // A row left beyond the rows in use (after row_count shrank)
            // samples nothing and falls back to the first row.
            if (w_row_live && (w_row_inc < w_rows)) begin
                n_active_row = w_row_inc[ROW_W-1:0];
            end else begin
                n_active_row = '0;
            end
            // A new frame starts: the next history position is used.
            if (n_active_row == '0) begin
                n_hist_pos = (r_hist_pos == POS_LAST) ? '0 : r_hist_pos + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active_row <= '0;
            r_hist_pos   <= '0;
        end else begin
            r_active_row <= n_active_row;
            r_hist_pos   <= n_hist_pos;
        end
    end

    // Key numbers of the active row run from w_base up to, not including, w_row_end.
    logic [6:0] w_base;
    logic [6:0] w_row_end;

    assign w_base    = 7'(w_row_ext) * 7'(w_cols);
    assign w_row_end = w_base + 7'(w_cols);

    // One lane per key slot. A lane takes the sample of its own column when its
    // key lies in the active row; slots past the matrix simply never update.
    logic [KEY_SLOTS-1:0] w_debounced;

    for (genvar k = 0; k < KEY_SLOTS; k++) begin : g_lane
        localparam logic [6:0] KEY_NUM = 7'(k);
        logic       w_in_row;
        logic [6:0] w_offset;
        logic [2:0] w_col;

        assign w_in_row = w_row_live && (KEY_NUM >= w_base) && (KEY_NUM < w_row_end);
        assign w_offset = KEY_NUM - w_base;
        assign w_col    = w_offset[2:0];

        kms_key_lane #(
            .HIST_LEN (HISTORY_LENGTH)
        ) u_lane (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_we     (w_tick && w_in_row),
            .i_closed (~i_column_levels[w_col]),
            .i_pos    (r_hist_pos),
            .o_down   (w_debounced[k])
        );
    end

    // The lanes' debounced bits merge into one bitmap for the snapshot stage.
    logic [KEY_SLOTS-1:0] w_down;
    logic [KEY_SLOTS-1:0] w_pressed;
    logic [KEY_SLOTS-1:0] w_released;

    kms_snap u_snap (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_snap      (w_snap),
        .i_debounced (w_debounced),
        .o_down      (w_down),
        .o_pressed   (w_pressed),
        .o_released  (w_released)
    );

    // The result word reflects the state after the accepted command.
    t_result w_result;
    t_result w_out;

    always_comb begin
        w_result.row_drive         = 4'hF & ~(4'b0001 << 4'(n_active_row));
        w_result.keys_down         = w_down;
        w_result.keys_pressed      = w_pressed;
        w_result.keys_released     = w_released;
        w_result.selected_down     = w_down[i_key_index];
        w_result.selected_pressed  = w_pressed[i_key_index];
        w_result.selected_released = w_released[i_key_index];
    end

    kms_out_q u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_accept),
        .i_data  (w_result),
        .o_full  (w_q_full),
        .o_valid (o_valid),
        .i_pop   (!i_stall),
        .o_data  (w_out)
    );

    assign o_row_drive         = w_out.row_drive;
    assign o_keys_down         = w_out.keys_down;
    assign o_keys_pressed      = w_out.keys_pressed;
    assign o_keys_released     = w_out.keys_released;
    assign o_selected_down     = w_out.selected_down;
    assign o_selected_pressed  = w_out.selected_pressed;
    assign o_selected_released = w_out.selected_released;

endmodule

[bench/tb.sv]
`timescale 1ns / 1ps

module tb;

    import kms_pkg::*;

    // The debounce history is one byte per key, as the block is built by default.
    localparam int HIST_W      = 8;
    localparam int ROWS_MAX    = 4;
    localparam int COLS_MAX    = 8;
    localparam int PHASES      = 8;
    localparam int PHASE_WORDS = 200;
    localparam int FREEZE_LEN  = 60;
    localparam int STUCK_LIMIT = 1000;

    // One input word as it waits to be driven, with the pause that follows it.
    typedef struct {
        logic               command;
        logic [LEVEL_W-1:0] levels;
        logic [KEY_W-1:0]   key_index;
        int                 gap;
    } t_scan_word;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  in_valid  = 1'b0;
    logic                  in_command = CMD_SCAN;
    logic [LEVEL_W-1:0]    in_levels = '0;
    logic [KEY_W-1:0]      in_key    = '0;
    logic                  out_stall = 1'b0;
    logic                  cfg_we    = 1'b0;
    logic [CFGIDX_W-1:0]   cfg_index = REG_ROW_COUNT;
    logic [CFG_W-1:0]      cfg_data  = '0;

    logic                  o_stall;
    logic                  o_valid;
    logic [DRIVE_W-1:0]    o_row_drive;
    logic [KEY_SLOTS-1:0]  o_keys_down;
    logic [KEY_SLOTS-1:0]  o_keys_pressed;
    logic [KEY_SLOTS-1:0]  o_keys_released;
    logic                  o_selected_down;
    logic                  o_selected_pressed;
    logic                  o_selected_released;

    key_matrix_scan_debounce u_dut (
        .i_clk               (clk),
        .i_rst_n             (rst_n),
        .i_valid             (in_valid),
        .o_stall             (o_stall),
        .i_command           (in_command),
        .i_column_levels     (in_levels),
        .i_key_index         (in_key),
        .o_valid             (o_valid),
        .i_stall             (out_stall),
        .o_row_drive         (o_row_drive),
        .o_keys_down         (o_keys_down),
        .o_keys_pressed      (o_keys_pressed),
        .o_keys_released     (o_keys_released),
        .o_selected_down     (o_selected_down),
        .o_selected_pressed  (o_selected_pressed),
        .o_selected_released (o_selected_released),
        .i_cfg_we            (cfg_we),
        .i_cfg_index         (cfg_index),
        .i_cfg_data          (cfg_data)
    );

    // Free-running 2 ns clock.
    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------------
    // Scanner prediction. This is our own copy of the matrix state: one sample
    // history per key slot, the debounced bitmap, the bitmaps latched by the
    // last snapshot, and the row and history-slot counters.
    // ------------------------------------------------------------------------
    logic [HIST_W-1:0]    key_history [KEY_SLOTS] = '{default: '0};
    logic [KEY_SLOTS-1:0] debounced_bits = '0;
    logic [KEY_SLOTS-1:0] latched_bits   = '0;
    logic [KEY_SLOTS-1:0] pressed_bits   = '0;
    logic [KEY_SLOTS-1:0] released_bits  = '0;
    logic [2:0]           hist_slot      = '0;
    int                   scan_row       = 0;
    logic [ROWREG_W-1:0]  row_reg        = ROW_COUNT_RST;
    logic [COLREG_W-1:0]  col_reg        = COLUMN_COUNT_RST;

    // A count of zero behaves as one, and anything past the matrix size as the maximum.
    function automatic int clamped(int value, int limit);
        if (value < 1) return 1;
        if (value > limit) return limit;
        return value;
    endfunction

    // Advances the predicted scanner by one word and returns the result word it
    // produces. Results always reflect the state after the word has taken effect.
    function automatic t_result debounce_step(input t_scan_word w);
        int                rows;
        int                cols;
        int                col;
        int                key;
        logic [HIST_W-1:0] h;
        t_result           r;
        rows = clamped(row_reg, ROWS_MAX);
        cols = clamped(col_reg, COLS_MAX);
        if (w.command == CMD_SCAN) begin
            if (scan_row < rows) begin
                // The whole active row lands in the same history slot. Level low
                // means the switch is closed, which records a one.
                for (col = 0; col < cols; col++) begin
                    key = scan_row * cols + col;
                    if (key < KEY_SLOTS) begin
                        h = key_history[key];
                        h[hist_slot] = ~w.levels[col];
                        key_history[key] = h;
                        if (h == '0) begin
                            debounced_bits[key] = 1'b0;
                        end else if (h == '1) begin
                            debounced_bits[key] = 1'b1;
                        end
                    end
                end
                scan_row = (scan_row + 1 >= rows) ? 0 : scan_row + 1;
            end else begin
                // The row count shrank below the active row: nothing is sampled,
                // the scan simply restarts at the top row.
                scan_row = 0;
            end
            // A finished frame moves every key on to its next history slot.
            if (scan_row == 0) begin
                hist_slot = hist_slot + 3'd1;
            end
        end else begin
            pressed_bits  = debounced_bits & ~latched_bits;
            released_bits = latched_bits & ~debounced_bits;
            latched_bits  = debounced_bits;
        end
        r.row_drive           = '1;
        r.row_drive[scan_row] = 1'b0;
        r.keys_down           = latched_bits;
        r.keys_pressed        = pressed_bits;
        r.keys_released       = released_bits;
        r.selected_down       = latched_bits[w.key_index];
        r.selected_pressed    = pressed_bits[w.key_index];
        r.selected_released   = released_bits[w.key_index];
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Bookkeeping shared by the processes. The word and result counters only
    // grow, so a process that reads one a little early only waits longer.
    // ------------------------------------------------------------------------
    t_scan_word pending_words[$];
    t_result    expected_results[$];
    t_scan_word word_on_bus;
    t_result    want_word;
    int         words_queued  = 0;
    int         words_taken   = 0;
    int         results_seen  = 0;
    int         fail_count    = 0;
    bit         calm_send     = 1'b0;
    bit         calm_recv     = 1'b0;
    int         freeze_ask    = 0;
    int         freeze_seen   = 0;
    int         freeze_left   = 0;
    int         send_wait     = 0;
    int         recv_wait     = 0;
    int         stuck_cycles  = 0;
    int         gen_row       = 0;

    // Driver: offers the next pending word once the current one is taken and
    // its pause has run out. Every accepted word is run through the predictor
    // at the edge that accepts it, so the expectations stay in order.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            send_wait = 0;
        end else begin
            if (in_valid && !o_stall) begin
                expected_results.push_back(debounce_step(word_on_bus));
                words_taken++;
            end
            if (!in_valid || !o_stall) begin
                if (send_wait != 0) begin
                    send_wait--;
                    in_valid <= 1'b0;
                end else if (pending_words.size() != 0) begin
                    word_on_bus = pending_words.pop_front();
                    in_command <= word_on_bus.command;
                    in_levels  <= word_on_bus.levels;
                    in_key     <= word_on_bus.key_index;
                    in_valid   <= 1'b1;
                    send_wait  = word_on_bus.gap;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    task automatic check_field(string field, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            fail_count++;
            $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
        end
    endtask

    // Monitor: takes result words, checks them against the oldest prediction,
    // then may stall for a random time unless calm_recv is set. A freeze request
    // from the stimulus holds the output off for a long stretch so the block backs up.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
            recv_wait   = 0;
            freeze_left = 0;
        end else begin
            if (o_valid && !out_stall) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    fail_count++;
                    $display("%0t: result word with none expected, expected none, actual %h",
                             $time, o_keys_down);
                end else begin
                    want_word = expected_results.pop_front();
                    check_field("row_drive", 32'(want_word.row_drive), 32'(o_row_drive));
                    check_field("keys_down", want_word.keys_down, o_keys_down);
                    check_field("keys_pressed", want_word.keys_pressed, o_keys_pressed);
                    check_field("keys_released", want_word.keys_released, o_keys_released);
                    check_field("selected_down", 32'(want_word.selected_down),
                                32'(o_selected_down));
                    check_field("selected_pressed", 32'(want_word.selected_pressed),
                                32'(o_selected_pressed));
                    check_field("selected_released", 32'(want_word.selected_released),
                                32'(o_selected_released));
                end
                recv_wait = calm_recv ? 0 : $urandom_range(0, 4);
            end else if (recv_wait != 0) begin
                recv_wait--;
            end
            if (freeze_ask != freeze_seen) begin
                freeze_seen = freeze_ask;
                freeze_left = FREEZE_LEN;
            end else if (freeze_left != 0) begin
                freeze_left--;
            end
            out_stall <= (recv_wait != 0) || (freeze_left != 0);
        end
    end

    // Watchdog: a long run of cycles with no word moving on either side means
    // the block has hung.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && !o_stall) || (o_valid && !out_stall)) begin
            stuck_cycles = 0;
        end else begin
            stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("tb: failure");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------------

    // Queues one word. The generator follows the active row itself so that a
    // held key pattern is always offered while its own row is driven.
    task automatic queue_word(logic cmd, logic [LEVEL_W-1:0] lv, logic [KEY_W-1:0] idx);
        t_scan_word w;
        w.command   = cmd;
        w.levels    = lv;
        w.key_index = idx;
        w.gap       = calm_send ? 0 : $urandom_range(0, 4);
        pending_words.push_back(w);
        words_queued++;
        if (cmd == CMD_SCAN) begin
            gen_row = (gen_row + 1 < clamped(row_reg, ROWS_MAX)) ? gen_row + 1 : 0;
        end
    endtask

    task automatic wait_idle();
        do @(posedge clk);
        while (words_taken != words_queued || results_seen != words_queued);
    endtask

    // Registers are only written here, while nothing is in flight.
    task automatic write_reg(logic [CFGIDX_W-1:0] idx, logic [CFG_W-1:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        if (idx == REG_ROW_COUNT) begin
            row_reg = val[ROWREG_W-1:0];
        end else begin
            col_reg = val;
        end
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // Most of the traffic is a key pattern per row held for long enough to
    // settle, with the odd contact bounce and snapshots mixed in. About one
    // pattern in five is short or fully random so keys also stay unsettled.
    // The phase ends on the last row in use, so a following smaller row count
    // leaves the active row out of range.
    task automatic play_phase(int budget);
        int                 sent;
        int                 frames;
        int                 r;
        bit                 noisy;
        logic [LEVEL_W-1:0] lv;
        logic [LEVEL_W-1:0] pattern [ROWS_MAX];
        sent = 0;
        while (sent < budget) begin
            for (r = 0; r < ROWS_MAX; r++) begin
                case ($urandom_range(0, 3))
                    0: begin
                        pattern[r] = '1;
                    end
                    1: begin
                        pattern[r] = '0;
                    end
                    default: begin
                        pattern[r] = LEVEL_W'($urandom);
                    end
                endcase
            end
            noisy  = ($urandom_range(0, 4) == 0);
            frames = noisy ? $urandom_range(1, 7) : $urandom_range(HIST_W, HIST_W + 3);
            repeat (frames * clamped(row_reg, ROWS_MAX)) begin
                lv = noisy ? LEVEL_W'($urandom) : pattern[gen_row];
                if (!noisy && $urandom_range(0, 31) == 0) begin
                    lv[$urandom_range(0, LEVEL_W - 1)] ^= 1'b1;
                end
                queue_word(CMD_SCAN, lv, KEY_W'($urandom));
                sent++;
                if ($urandom_range(0, 9) == 0) begin
                    queue_word(CMD_SNAPSHOT, LEVEL_W'($urandom), KEY_W'($urandom));
                    sent++;
                end
            end
            queue_word(CMD_SNAPSHOT, LEVEL_W'($urandom), KEY_W'($urandom));
            sent++;
        end
        while (gen_row != clamped(row_reg, ROWS_MAX) - 1) begin
            queue_word(CMD_SCAN, LEVEL_W'($urandom), KEY_W'($urandom));
        end
    endtask

    // Register settings per phase, as raw values: zero and values past the
    // matrix size are included, and row counts often fall below the one before
    // them so the out-of-range row case comes up.
    logic [CFG_W-1:0] phase_rows [PHASES] = '{4'd4, 4'd2, 4'd0, 4'd7, 4'd3, 4'd8, 4'd4, 4'd1};
    logic [CFG_W-1:0] phase_cols [PHASES] = '{4'd8, 4'd5, 4'd0, 4'd15, 4'd3, 4'd9, 4'd2, 4'd7};

    initial begin
        int phase;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on a single row of eight keys, so one frame is one tick
        // and a full debounce takes eight words.
        write_reg(REG_ROW_COUNT, 4'd1);
        write_reg(REG_COLUMN_COUNT, 4'd8);
        gen_row = scan_row;
        queue_word(CMD_SNAPSHOT, 8'h00, 5'd0);
        for (phase = 0; phase < HIST_W; phase++) begin
            queue_word(CMD_SCAN, 8'h00, (phase % 2 == 0) ? 5'd0 : 5'd31);
        end
        queue_word(CMD_SNAPSHOT, 8'hff, 5'd3);
        queue_word(CMD_SNAPSHOT, 8'h00, 5'd31);
        for (phase = 0; phase < HIST_W; phase++) begin
            queue_word(CMD_SCAN, 8'hff, 5'd7);
        end
        queue_word(CMD_SNAPSHOT, 8'h5a, 5'd7);
        queue_word(CMD_SCAN, 8'h55, 5'd0);
        queue_word(CMD_SCAN, 8'haa, 5'd31);

        // Random phases. Phase two runs with no idling at all; phase three has
        // the sender streaming while the receiver is frozen; phase five has a
        // receiver that never stalls. Each phase starts only after every
        // result of the one before has come back.
        for (phase = 0; phase < PHASES; phase++) begin
            wait_idle();
            write_reg(REG_ROW_COUNT, phase_rows[phase]);
            write_reg(REG_COLUMN_COUNT, phase_cols[phase]);
            gen_row   = scan_row;
            calm_send = (phase == 2 || phase == 3);
            calm_recv = (phase == 2 || phase == 5);
            if (phase == 3) begin
                @(posedge clk);
                freeze_ask <= freeze_ask + 1;
            end
            play_phase(PHASE_WORDS);
        end

        wait_idle();
        repeat (4) @(posedge clk);
        if (fail_count == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/kms_pkg.sv
rtl/kms_key_lane.sv
rtl/kms_snap.sv
rtl/kms_out_q.sv
rtl/key_matrix_scan_debounce.sv
bench/tb.sv
